// ===== rtl/positional_list_engine_macros.svh =====
// Assertion macros used by the checker file of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine check failed");

`endif

// ===== rtl/ple_pkg.sv =====
// Package of the positional list engine: request and status codes, defaults, cell control.
`default_nettype none

package ple_pkg;

    // Default parameter values.
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Request codes.
    localparam logic [2:0] REQ_INS_HEAD = 3'd0;
    localparam logic [2:0] REQ_INS_TAIL = 3'd1;
    localparam logic [2:0] REQ_INS_AT   = 3'd2;
    localparam logic [2:0] REQ_DEL_HEAD = 3'd3;
    localparam logic [2:0] REQ_DEL_TAIL = 3'd4;
    localparam logic [2:0] REQ_DEL_AT   = 3'd5;
    localparam logic [2:0] REQ_DUMP     = 3'd6;

    // Status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    // Per-cell load selects; at most one is set in any cycle.
    typedef struct packed {
        logic load_new;
        logic from_left;
        logic from_right;
        logic from_head;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// One storage cell of the list chain, loading from its neighbors, the head or a new word.
`default_nettype none

module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire ple_pkg::cell_ctl_t    ctl,
    input  wire logic [DATA_WIDTH-1:0] new_value,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [DATA_WIDTH-1:0] head_data,
    output logic      [DATA_WIDTH-1:0] data
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Select the source for this cell; hold when no select is set.
    always_comb
    begin
        if (ctl.load_new)
        begin
            data_next = new_value;
        end
        else if (ctl.from_left)
        begin
            data_next = left_data;
        end
        else if (ctl.from_right)
        begin
            data_next = right_data;
        end
        else if (ctl.from_head)
        begin
            data_next = head_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: request decode, fill count and the chain of cells.
`default_nettype none

// The list lives in a row of DEPTH cells, cell 0 being the head. An insert or a
// delete shifts the affected cells by one place at once, so such a request
// gives one result transfer. A dump of a non-empty list holds off further
// requests until its last element goes to the output stage, while the chain
// rotates the stored elements through cell 0, one element per result transfer,
// so the list is back in order when the dump ends. One
// request is worked at a time; no request is taken while a dump is running. A
// registered output stage holds each result, and a new request is taken in the
// cycle the pending result is taken. Element values are stored as their low
// DATA_WIDTH bits and read back sign-extended.
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: value[31:0], position[37:32], zero fill.
    input  wire logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: req_type[2:0].
    input  wire logic [ple_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0: count[5:0], element[37:6], zero fill.
    output logic      [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic      [ple_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import ple_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = ((FW > 6) ? FW : 6) + 1;
    localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         fill_next;
    logic [FW-1:0]         dcnt_reg;
    logic [FW-1:0]         dcnt_next;

    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [5:0]            m_count_reg;
    logic [31:0]           m_elem_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  accept;
    logic                  load_out;
    logic [1:0]            o_status;
    logic [31:0]           o_elem;
    logic                  o_last;

    logic                  op_ins;
    logic                  op_del;
    logic                  op_rot;
    logic [CW-1:0]         op_idx;

    logic [2:0]            req;
    logic [5:0]            pos;
    logic [CW-1:0]         pos_w;
    logic [CW-1:0]         fill_w;
    logic [CW-1:0]         fill_m1;
    logic                  dump_last;
    logic [DATA_WIDTH-1:0] new_word;

    cell_ctl_t             ctl       [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] left_w    [DEPTH];
    logic [DATA_WIDTH-1:0] right_w   [DEPTH];

    // Input field unpacking.
    assign req      = s_axis_tuser[2:0];
    assign pos      = s_axis_tdata[37:32];
    assign new_word = DATA_WIDTH'($signed(s_axis_tdata[31:0]));
    assign pos_w    = CW'(pos);
    assign fill_w   = CW'(fill_reg);
    assign fill_m1  = fill_w - CW'(1);

    // Handshake: one request at a time, taken when the output stage frees up.
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign dump_last     = (dcnt_reg == fill_reg - FW'(1));

    // Request decode, status checks and dump sequencing.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        dcnt_next  = dcnt_reg;
        load_out   = 1'b0;
        o_status   = STAT_OK;
        o_elem     = '0;
        o_last     = 1'b1;
        op_ins     = 1'b0;
        op_del     = 1'b0;
        op_rot     = 1'b0;
        op_idx     = '0;

        if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                load_out = 1'b1;
                unique case (req) inside
                    REQ_INS_HEAD, REQ_INS_TAIL:
                    begin
                        if (fill_reg == FULL_FILL)
                        begin
                            o_status = STAT_FULL;
                        end
                        else
                        begin
                            op_ins    = 1'b1;
                            op_idx    = (req == REQ_INS_HEAD) ? '0 : fill_w;
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    REQ_INS_AT:
                    begin
                        if (pos == 6'd0 || pos_w > fill_w + CW'(1))
                        begin
                            o_status = STAT_BADPOS;
                        end
                        else if (fill_reg == FULL_FILL)
                        begin
                            o_status = STAT_FULL;
                        end
                        else
                        begin
                            op_ins    = 1'b1;
                            op_idx    = pos_w - CW'(1);
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    REQ_DEL_HEAD, REQ_DEL_TAIL:
                    begin
                        if (fill_reg == '0)
                        begin
                            o_status = STAT_EMPTY;
                        end
                        else
                        begin
                            op_del    = 1'b1;
                            op_idx    = (req == REQ_DEL_HEAD) ? '0 : fill_m1;
                            fill_next = fill_reg - FW'(1);
                        end
                    end
                    REQ_DEL_AT:
                    begin
                        if (fill_reg == '0)
                        begin
                            o_status = STAT_EMPTY;
                        end
                        else if (pos == 6'd0 || pos_w > fill_w)
                        begin
                            o_status = STAT_BADPOS;
                        end
                        else
                        begin
                            op_del    = 1'b1;
                            op_idx    = pos_w - CW'(1);
                            fill_next = fill_reg - FW'(1);
                        end
                    end
                    REQ_DUMP:
                    begin
                        if (fill_reg == '0)
                        begin
                            o_status = STAT_EMPTY;
                        end
                        else
                        begin
                            load_out   = 1'b0;
                            dcnt_next  = '0;
                            state_next = ST_DUMP;
                        end
                    end
                    default:
                    begin
                        // The unused request code leaves the list alone.
                    end
                endcase
            end
        end
        else
        begin
            // Dump: read the head and rotate the occupied cells by one place.
            if (out_free)
            begin
                load_out  = 1'b1;
                o_elem    = 32'($signed(cell_data[0]));
                o_last    = dump_last;
                op_rot    = 1'b1;
                dcnt_next = dcnt_reg + FW'(1);
                if (dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            dcnt_reg  <= dcnt_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_status_reg <= o_status;
            m_count_reg  <= 6'(fill_next);
            m_elem_reg   <= o_elem;
            m_last_reg   <= o_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_elem_reg, m_count_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    // The chain of cells with its per-cell shift selects.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] CI = CW'(i);

        if (i == 0)
        begin : g_first
            assign left_w[i] = cell_data[i];
        end
        else
        begin : g_inner_l
            assign left_w[i] = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w[i] = cell_data[i];
        end
        else
        begin : g_inner_r
            assign right_w[i] = cell_data[i+1];
        end

        assign ctl[i].load_new   = op_ins && (CI == op_idx);
        assign ctl[i].from_left  = op_ins && (CI > op_idx);
        assign ctl[i].from_right = (op_del && (CI >= op_idx)) || (op_rot && (CI < fill_m1));
        assign ctl[i].from_head  = op_rot && (CI == fill_m1);

        ple_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .new_value (new_word),
            .left_data (left_w[i]),
            .right_data(right_w[i]),
            .head_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/ple_checker.sv =====
// Port-level checker of the positional list engine and its bind to the top level.
`default_nettype none

`include "positional_list_engine_macros.svh"

module ple_checker #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [ple_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [ple_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input wire logic                            m_axis_tlast
);
    import ple_pkg::*;

    localparam logic [5:0] FULL_COUNT = 6'(DEPTH);

    // A stalled result transfer keeps its payload.
    `PLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Any failing status ends its request.
    `PLE_ASSERT_IMPL(a_fail_last, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tlast)

    // A full list reports the full count.
    `PLE_ASSERT_IMPL(a_full_count, m_axis_tvalid && (m_axis_tuser == STAT_FULL), m_axis_tdata[5:0] == FULL_COUNT)

    // An empty list reports a zero count and a zero element.
    `PLE_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && (m_axis_tuser == STAT_EMPTY), m_axis_tdata[37:0] == 38'd0)

    // No request is taken while a dump still has elements to give.
    `PLE_ASSERT_IMPL(a_dump_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind positional_list_engine ple_checker #(
    .DEPTH(DEPTH)
) u_ple_checker (.*);

`default_nettype wire
